// ----- hw/rtl/ifmt_pkg.sv -----
// Package for the integer field formatter: field codes, character constants,
// microcode types and the status bundle shared by the sequencer and datapath.
// No dependencies.
package ifmt_pkg;

    localparam int MAX_FIELD = 64;
    localparam int CNT_W     = $clog2(MAX_FIELD + 1);
    localparam int IN_DATA_W = 56;
    localparam int DIG_MAX   = 11;
    localparam int DIG_IDX_W = $clog2(DIG_MAX);

    localparam logic [2:0] MODE_SDEC  = 3'd0;
    localparam logic [2:0] MODE_UDEC  = 3'd1;
    localparam logic [2:0] MODE_OCT   = 3'd2;
    localparam logic [2:0] MODE_HEXL  = 3'd3;
    localparam logic [2:0] MODE_HEXU  = 3'd4;
    localparam logic [2:0] MODE_CHAR  = 3'd5;

    localparam logic [2:0] FLAG_NONE  = 3'd0;
    localparam logic [2:0] FLAG_MINUS = 3'd1;
    localparam logic [2:0] FLAG_PLUS  = 3'd2;
    localparam logic [2:0] FLAG_SPACE = 3'd3;
    localparam logic [2:0] FLAG_HASH  = 3'd4;
    localparam logic [2:0] FLAG_ZERO  = 3'd5;

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_LOWER_X = 8'd120;
    localparam logic [7:0] CH_UPPER_X = 8'd88;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;

    typedef logic [3:0] upc_t;

    localparam upc_t STEP_IDLE  = 4'd0;
    localparam upc_t STEP_PREP  = 4'd1;
    localparam upc_t STEP_CHECK = 4'd2;
    localparam upc_t STEP_DIGA  = 4'd3;
    localparam upc_t STEP_DIGB  = 4'd4;
    localparam upc_t STEP_SIZE  = 4'd5;
    localparam upc_t STEP_SIZE2 = 4'd6;
    localparam upc_t STEP_TEST  = 4'd7;
    localparam upc_t STEP_LPAD  = 4'd8;
    localparam upc_t STEP_PRE   = 4'd9;
    localparam upc_t STEP_ZPAD  = 4'd10;
    localparam upc_t STEP_ZEROS = 4'd11;
    localparam upc_t STEP_DIG   = 4'd12;
    localparam upc_t STEP_RPAD  = 4'd13;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_PREP,
        OP_NOP,
        OP_DIGA,
        OP_DIGB,
        OP_SIZE,
        OP_SIZE2,
        OP_LPAD,
        OP_PRE,
        OP_ZPAD,
        OP_ZEROS,
        OP_DIG,
        OP_RPAD
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_BAD_MODE,
        C_NO_DIGITS,
        C_MORE_DIGITS,
        C_EMPTY,
        C_EMIT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic bad_mode;
        logic no_digits;
        logic more_digits;
        logic empty;
        logic seg_active;
        logic hold;
        logic finish;
    } status_t;

endpackage

// ----- hw/rtl/ifmt_seq.sv -----
// Microcode sequencer of the integer field formatter: step counter, control
// store and conditional next-step logic. Depends on ifmt_pkg.
module ifmt_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ifmt_pkg::status_t status,
    output ifmt_pkg::ctrl_t   ctrl,
    output logic              in_ready
);
    import ifmt_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    function automatic ctrl_t ucode(input upc_t addr);
        ctrl_t w;
        case (addr)
            STEP_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_INPUT,    target: STEP_IDLE};
            STEP_PREP:  w = '{op: OP_PREP,  cond: C_BAD_MODE,    target: STEP_IDLE};
            STEP_CHECK: w = '{op: OP_NOP,   cond: C_NO_DIGITS,   target: STEP_SIZE};
            STEP_DIGA:  w = '{op: OP_DIGA,  cond: C_NONE,        target: STEP_IDLE};
            STEP_DIGB:  w = '{op: OP_DIGB,  cond: C_MORE_DIGITS, target: STEP_DIGA};
            STEP_SIZE:  w = '{op: OP_SIZE,  cond: C_NONE,        target: STEP_IDLE};
            STEP_SIZE2: w = '{op: OP_SIZE2, cond: C_NONE,        target: STEP_IDLE};
            STEP_TEST:  w = '{op: OP_NOP,   cond: C_EMPTY,       target: STEP_IDLE};
            STEP_LPAD:  w = '{op: OP_LPAD,  cond: C_EMIT,        target: STEP_LPAD};
            STEP_PRE:   w = '{op: OP_PRE,   cond: C_EMIT,        target: STEP_PRE};
            STEP_ZPAD:  w = '{op: OP_ZPAD,  cond: C_EMIT,        target: STEP_ZPAD};
            STEP_ZEROS: w = '{op: OP_ZEROS, cond: C_EMIT,        target: STEP_ZEROS};
            STEP_DIG:   w = '{op: OP_DIG,   cond: C_EMIT,        target: STEP_DIG};
            STEP_RPAD:  w = '{op: OP_RPAD,  cond: C_EMIT,        target: STEP_RPAD};
            default:    w = '{op: OP_NOP,   cond: C_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl     = ucode(upc_reg);
    assign in_ready = (ctrl.op == OP_LOAD);

    always_comb
    begin
        case (ctrl.cond)
            C_NONE:        cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_INPUT:    cond_true = !in_valid;
            C_BAD_MODE:    cond_true = status.bad_mode;
            C_NO_DIGITS:   cond_true = status.no_digits;
            C_MORE_DIGITS: cond_true = status.more_digits;
            C_EMPTY:       cond_true = status.empty;
            C_EMIT:        cond_true = status.seg_active;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (status.finish)
        begin
            upc_next = STEP_IDLE;
        end
        else if (status.hold)
        begin
            upc_next = upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = ctrl.target;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- hw/rtl/ifmt_dp.sv -----
// Datapath of the integer field formatter: request registers, digit
// extraction, field sizing and the character output register. Depends on ifmt_pkg.
module ifmt_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ifmt_pkg::ctrl_t                ctrl,
    input  logic                           in_valid,
    input  logic [ifmt_pkg::IN_DATA_W-1:0] in_data,
    input  logic [2:0]                     in_user,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [7:0]                     out_data,
    output logic                           out_last,
    output ifmt_pkg::status_t              status
);
    import ifmt_pkg::*;

    logic [2:0]           mode_reg;
    logic [31:0]          val_reg;
    logic                 short_reg;
    logic [2:0]           flag_reg;
    logic [6:0]           width_reg;
    logic                 pg_reg;
    logic [5:0]           prec_reg;
    logic [31:0]          mag_reg;
    logic                 neg_reg;
    logic [7:0]           chr_reg;
    logic [28:0]          quot_reg;
    logic [3:0]           dig_reg [DIG_MAX];
    logic [DIG_IDX_W-1:0] ndig_reg;
    logic [5:0]           zeros_reg;
    logic [1:0]           npre_reg;
    logic [7:0]           pre0_reg;
    logic [7:0]           pre1_reg;
    logic                 zfill_reg;
    logic [6:0]           pad_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 left;
    logic [31:0]          sext_val;
    logic                 neg_now;
    logic [31:0]          mag_now;
    logic [63:0]          prod;
    logic [31:0]          quot_x10;
    logic [31:0]          rem10;
    logic [3:0]           digit;
    logic [31:0]          mag_next;
    logic [5:0]           prec_eff;
    logic [5:0]           ndig6;
    logic [5:0]           zeros_now;
    logic [6:0]           body;
    logic [6:0]           len;
    logic [CNT_W-1:0]     n_now;
    logic [3:0]           rd_dig;
    logic [7:0]           alpha;
    logic [7:0]           dig_char;
    logic [7:0]           emit_char;
    logic                 seg_active;
    logic                 can_push;
    logic                 push;
    logic                 is_last;

    assign accept = (ctrl.op == OP_LOAD) && in_valid;
    assign left   = (flag_reg == FLAG_MINUS);

    always_comb
    begin
        if (!short_reg)
        begin
            sext_val = val_reg;
        end
        else if (mode_reg == MODE_SDEC)
        begin
            sext_val = {{16{val_reg[15]}}, val_reg[15:0]};
        end
        else
        begin
            sext_val = {16'd0, val_reg[15:0]};
        end
        neg_now = (mode_reg == MODE_SDEC) && sext_val[31];
        mag_now = neg_now ? (32'd0 - sext_val) : sext_val;
    end

    assign prod     = {32'd0, mag_reg} * {32'd0, RECIP_10};
    assign quot_x10 = {quot_reg, 3'd0} + {2'd0, quot_reg, 1'b0};
    assign rem10    = mag_reg - quot_x10;

    always_comb
    begin
        if (mode_reg == MODE_OCT)
        begin
            digit    = {1'b0, mag_reg[2:0]};
            mag_next = {3'd0, mag_reg[31:3]};
        end
        else if ((mode_reg == MODE_HEXL) || (mode_reg == MODE_HEXU))
        begin
            digit    = mag_reg[3:0];
            mag_next = {4'd0, mag_reg[31:4]};
        end
        else
        begin
            digit    = rem10[3:0];
            mag_next = {3'd0, quot_reg};
        end
    end

    assign ndig6    = {{(6 - DIG_IDX_W){1'b0}}, ndig_reg};
    assign prec_eff = pg_reg ? prec_reg : 6'd1;

    always_comb
    begin
        zeros_now = (prec_eff > ndig6) ? (prec_eff - ndig6) : 6'd0;
        if ((flag_reg == FLAG_HASH) && (mode_reg == MODE_OCT) && (zeros_now == 6'd0))
        begin
            zeros_now = 6'd1;
        end
        if (mode_reg == MODE_CHAR)
        begin
            zeros_now = 6'd0;
        end
    end

    assign body = {5'd0, npre_reg} + {1'b0, zeros_reg} + {{(7 - DIG_IDX_W){1'b0}}, ndig_reg};
    assign len  = (width_reg > body) ? width_reg : body;

    always_comb
    begin
        if (32'(len) > MAX_FIELD)
        begin
            n_now = CNT_W'(MAX_FIELD);
        end
        else
        begin
            n_now = CNT_W'(len);
        end
    end

    assign rd_dig   = dig_reg[ndig_reg - DIG_IDX_W'(1)];
    assign alpha    = (mode_reg == MODE_HEXU) ? CH_UPPER_A : CH_LOWER_A;
    assign dig_char = (rd_dig < 4'd10) ? (CH_ZERO + {4'd0, rd_dig})
                                       : (alpha + {4'd0, rd_dig} - 8'd10);

    always_comb
    begin
        seg_active = 1'b0;
        emit_char  = CH_SPACE;
        case (ctrl.op)
            OP_LPAD:
            begin
                seg_active = !left && !zfill_reg && (pad_reg != 7'd0);
            end
            OP_PRE:
            begin
                seg_active = (npre_reg != 2'd0);
                emit_char  = pre0_reg;
            end
            OP_ZPAD:
            begin
                seg_active = zfill_reg && (pad_reg != 7'd0);
                emit_char  = CH_ZERO;
            end
            OP_ZEROS:
            begin
                seg_active = (zeros_reg != 6'd0);
                emit_char  = CH_ZERO;
            end
            OP_DIG:
            begin
                seg_active = (ndig_reg != '0);
                emit_char  = (mode_reg == MODE_CHAR) ? chr_reg : dig_char;
            end
            OP_RPAD:
            begin
                seg_active = left && (pad_reg != 7'd0);
            end
            default:
            begin
                seg_active = 1'b0;
            end
        endcase
    end

    assign can_push = !out_valid_reg || out_ready;
    assign push     = seg_active && can_push;
    assign is_last  = (cnt_reg == (n_reg - CNT_W'(1)));

    assign status = '{
        bad_mode:    (mode_reg > MODE_CHAR),
        no_digits:   (mag_reg == 32'd0) || (mode_reg == MODE_CHAR),
        more_digits: (mag_next != 32'd0),
        empty:       (n_reg == '0),
        seg_active:  seg_active,
        hold:        seg_active && !can_push,
        finish:      push && is_last
    };

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_user;
            val_reg   <= in_data[31:0];
            short_reg <= in_data[32];
            flag_reg  <= in_data[35:33];
            width_reg <= in_data[42:36];
            pg_reg    <= in_data[43];
            prec_reg  <= in_data[49:44];
        end
        case (ctrl.op)
            OP_PREP:
            begin
                mag_reg  <= mag_now;
                neg_reg  <= neg_now;
                chr_reg  <= val_reg[7:0];
                ndig_reg <= (mode_reg == MODE_CHAR) ? DIG_IDX_W'(1) : '0;
            end
            OP_DIGA:
            begin
                quot_reg <= prod[63:35];
            end
            OP_DIGB:
            begin
                dig_reg[ndig_reg] <= digit;
                ndig_reg          <= ndig_reg + DIG_IDX_W'(1);
                mag_reg           <= mag_next;
            end
            OP_SIZE:
            begin
                zeros_reg <= zeros_now;
                zfill_reg <= (flag_reg == FLAG_ZERO) && !pg_reg && (mode_reg != MODE_CHAR);
                pre1_reg  <= (mode_reg == MODE_HEXU) ? CH_UPPER_X : CH_LOWER_X;
                if ((mode_reg == MODE_SDEC) && neg_reg)
                begin
                    npre_reg <= 2'd1;
                    pre0_reg <= CH_MINUS;
                end
                else if ((mode_reg == MODE_SDEC) && (flag_reg == FLAG_PLUS))
                begin
                    npre_reg <= 2'd1;
                    pre0_reg <= CH_PLUS;
                end
                else if ((mode_reg == MODE_SDEC) && (flag_reg == FLAG_SPACE))
                begin
                    npre_reg <= 2'd1;
                    pre0_reg <= CH_SPACE;
                end
                else if ((flag_reg == FLAG_HASH) && (ndig_reg != '0) &&
                         ((mode_reg == MODE_HEXL) || (mode_reg == MODE_HEXU)))
                begin
                    npre_reg <= 2'd2;
                    pre0_reg <= CH_ZERO;
                end
                else
                begin
                    npre_reg <= 2'd0;
                    pre0_reg <= CH_ZERO;
                end
            end
            OP_SIZE2:
            begin
                pad_reg <= (width_reg > body) ? (width_reg - body) : 7'd0;
                n_reg   <= n_now;
                cnt_reg <= '0;
            end
            default:
            begin
            end
        endcase
        if (push)
        begin
            cnt_reg      <= cnt_reg + CNT_W'(1);
            out_char_reg <= emit_char;
            out_last_reg <= is_last;
            case (ctrl.op)
                OP_LPAD, OP_ZPAD, OP_RPAD:
                begin
                    pad_reg <= pad_reg - 7'd1;
                end
                OP_PRE:
                begin
                    npre_reg <= npre_reg - 2'd1;
                    pre0_reg <= pre1_reg;
                end
                OP_ZEROS:
                begin
                    zeros_reg <= zeros_reg - 6'd1;
                end
                OP_DIG:
                begin
                    ndig_reg <= ndig_reg - DIG_IDX_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- hw/rtl/integer_field_formatter.sv -----
// Integer field formatter top level: one printf-style integer or character field per request.
// Steps: load, prepare, extract digits least significant first, size the field, then emit the
// left pad, prefix, zero pad, precision zeros, digits and right pad; empty runs emit nothing.
// A new request is taken only in the idle step, once the previous field's last character has
// entered the single character output register or the request was dropped as reserved or empty.
// Reset: rst_n (asynchronous, active low) clears the step counter and output valid only.
// Depends on ifmt_pkg, ifmt_seq and ifmt_dp.
module integer_field_formatter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value[31:0], short_mod[32], flag[35:33], width[42:36], prec_given[43], precision[49:44]
    input  logic [ifmt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // char_out[7:0]
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast
);
    import ifmt_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    ifmt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (s_axis_tready)
    );

    ifmt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .status    (status)
    );

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sequencer stayed ready after accepting a request");

    a_idle_only_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("sequencer idle while a field is only partly sent");

    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for integer_field_formatter: directed and random printf-style
// conversion requests, with the expected characters predicted inside the bench.
// Depends on ifmt_pkg and the integer_field_formatter RTL.
`timescale 1ns / 1ps

module testbench;
    import ifmt_pkg::*;

    localparam int LIMIT_CYCLES  = 4000000;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int MAX_REPORTS   = 40;
    localparam int RANDOM_ITEMS  = 50;
    localparam int BURST_ITEMS   = 12;

    localparam logic [2:0] MODE_RSVD_A = 3'd6;
    localparam logic [2:0] MODE_RSVD_B = 3'd7;
    localparam logic [2:0] FLAG_RSVD_A = 3'd6;
    localparam logic [2:0] FLAG_RSVD_B = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic        short_mod;
        logic [2:0]  flag;
        logic [6:0]  field_width;
        logic        prec_given;
        logic [5:0]  precision;
    } format_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    field_char_t pending_chars[$];
    int unsigned error_count = 0;
    int unsigned chars_seen  = 0;
    int unsigned cycle_count = 0;
    logic        long_hold_req;
    logic        idle_enable;

    integer_field_formatter u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    function automatic void format_field(input format_req_t req);
        logic [7:0]  text[$];
        logic [7:0]  prefix[$];
        logic [7:0]  digits[$];
        logic [31:0] signed_val;
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] digit;
        logic [7:0]  alpha;
        int unsigned zeros;
        int unsigned body;
        int unsigned pad;
        int unsigned prec;
        int unsigned count;
        logic        left_just;
        logic        zero_fill;
        field_char_t entry;
        left_just = (req.flag == FLAG_MINUS);
        zero_fill = 1'b0;
        zeros = 0;
        if (req.mode > MODE_CHAR)
            return;
        if (req.mode == MODE_CHAR)
        begin
            digits.push_back(req.value[7:0]);
        end
        else
        begin
            alpha = (req.mode == MODE_HEXU) ? CH_UPPER_A : CH_LOWER_A;
            if (req.mode == MODE_SDEC)
            begin
                signed_val = req.short_mod ? {{16{req.value[15]}}, req.value[15:0]} : req.value;
                mag = signed_val[31] ? 32'd0 - signed_val : signed_val;
                if (signed_val[31])
                    prefix.push_back(CH_MINUS);
                else if (req.flag == FLAG_PLUS)
                    prefix.push_back(CH_PLUS);
                else if (req.flag == FLAG_SPACE)
                    prefix.push_back(CH_SPACE);
            end
            else
            begin
                mag = req.short_mod ? {16'd0, req.value[15:0]} : req.value;
            end
            base = (req.mode == MODE_OCT) ? 32'd8 : ((req.mode >= MODE_HEXL) ? 32'd16 : 32'd10);
            while (mag != 0)
            begin
                digit = mag % base;
                if (digit < 10)
                    digits.push_front(CH_ZERO + 8'(digit));
                else
                    digits.push_front(alpha + 8'(digit - 10));
                mag = mag / base;
            end
            prec = req.prec_given ? req.precision : 1;
            zeros = (prec > digits.size()) ? prec - digits.size() : 0;
            if (req.flag == FLAG_HASH)
            begin
                if (req.mode == MODE_OCT && zeros == 0)
                    zeros = 1;
                if (req.mode >= MODE_HEXL && digits.size() != 0)
                begin
                    prefix.push_back(CH_ZERO);
                    prefix.push_back((req.mode == MODE_HEXU) ? CH_UPPER_X : CH_LOWER_X);
                end
            end
            zero_fill = (req.flag == FLAG_ZERO) && !req.prec_given;
        end
        body = prefix.size() + zeros + digits.size();
        pad = (req.field_width > body) ? req.field_width - body : 0;
        if (!left_just && !zero_fill)
            repeat (pad) text.push_back(CH_SPACE);
        foreach (prefix[i])
            text.push_back(prefix[i]);
        if (zero_fill)
            repeat (pad) text.push_back(CH_ZERO);
        repeat (zeros) text.push_back(CH_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
        if (left_just)
            repeat (pad) text.push_back(CH_SPACE);
        count = (text.size() < MAX_FIELD) ? text.size() : MAX_FIELD;
        for (int k = 0; k < count; k++)
        begin
            entry.ch = text[k];
            entry.last = (k + 1 == count);
            pending_chars.push_back(entry);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_enable)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 10)
            return 0;
        else if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 15)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic format_req_t make_req(input logic [2:0] mode, input logic [31:0] value,
                                             input logic short_mod, input logic [2:0] flag,
                                             input logic [6:0] field_width,
                                             input logic prec_given,
                                             input logic [5:0] precision);
        format_req_t req;
        req.mode = mode;
        req.value = value;
        req.short_mod = short_mod;
        req.flag = flag;
        req.field_width = field_width;
        req.prec_given = prec_given;
        req.precision = precision;
        return req;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return 32'd0 - $urandom_range(1, 20);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_8000;
                endcase
            end
            3: return {16'($urandom), 16'($urandom_range(32760, 32775))};
            default: return $urandom();
        endcase
    endfunction

    function automatic format_req_t rand_request();
        format_req_t req;
        if ($urandom_range(0, 19) == 0)
            req.mode = 3'($urandom_range(6, 7));
        else
            req.mode = 3'($urandom_range(0, 5));
        req.value = rand_value();
        req.short_mod = 1'($urandom_range(0, 1));
        req.flag = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 7) == 0)
            req.field_width = 7'($urandom_range(0, 127));
        else
            req.field_width = 7'($urandom_range(0, 16));
        req.prec_given = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 7) == 0)
            req.precision = 6'($urandom_range(0, 63));
        else
            req.precision = 6'($urandom_range(0, 12));
        return req;
    endfunction

    task automatic send_request(input format_req_t req);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, req.precision, req.prec_given, req.field_width, req.flag,
                          req.short_mod, req.value};
        s_axis_tuser  <= req.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        format_field(req);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_char();
        field_char_t want;
        if (pending_chars.size() == 0)
        begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      m_axis_tdata, m_axis_tlast));
        end
        else
        begin
            want = pending_chars.pop_front();
            if (m_axis_tdata !== want.ch)
                report_mismatch($sformatf("character %0d is 0x%02h, want 0x%02h",
                                          chars_seen, m_axis_tdata, want.ch));
            if (m_axis_tlast !== want.last)
                report_mismatch($sformatf("character %0d has last %0b, want %0b",
                                          chars_seen, m_axis_tlast, want.last));
        end
        chars_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_char();
    end

    initial
    begin : receiver
        int unsigned stall_left;
        logic        hold_served;
        stall_left = 0;
        hold_served = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                if (!long_hold_req)
                    hold_served = 1'b0;
                if (stall_left != 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                    m_axis_tready <= (stall_left == 0);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(make_req(MODE_SDEC, 32'd0, 1'b0, FLAG_NONE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'd0, 1'b0, FLAG_NONE, 7'd0, 1'b1, 6'd0));
        send_request(make_req(MODE_SDEC, 32'd0, 1'b0, FLAG_NONE, 7'd5, 1'b1, 6'd0));
        send_request(make_req(MODE_SDEC, 32'h8000_0000, 1'b0, FLAG_NONE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'h7FFF_FFFF, 1'b0, FLAG_PLUS, 7'd0, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'd42, 1'b0, FLAG_SPACE, 7'd8, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'h0000_8000, 1'b1, FLAG_ZERO, 7'd10, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'hFFFF_FFFB, 1'b0, FLAG_ZERO, 7'd6, 1'b1, 6'd3));
        send_request(make_req(MODE_UDEC, 32'hFFFF_FFFF, 1'b0, FLAG_PLUS, 7'd0, 1'b0, 6'd0));
        send_request(make_req(MODE_UDEC, 32'hABCD_FFFF, 1'b1, FLAG_MINUS, 7'd10, 1'b0, 6'd0));
        send_request(make_req(MODE_OCT, 32'd8, 1'b0, FLAG_HASH, 7'd0, 1'b0, 6'd0));
        send_request(make_req(MODE_OCT, 32'd0, 1'b0, FLAG_HASH, 7'd0, 1'b1, 6'd0));
        send_request(make_req(MODE_OCT, 32'hFFFF_FFFF, 1'b0, FLAG_HASH, 7'd0, 1'b1, 6'd12));
        send_request(make_req(MODE_HEXL, 32'hDEAD_BEEF, 1'b0, FLAG_HASH, 7'd14, 1'b0, 6'd0));
        send_request(make_req(MODE_HEXL, 32'hDEAD_BEEF, 1'b0, FLAG_ZERO, 7'd14, 1'b0, 6'd0));
        send_request(make_req(MODE_HEXU, 32'h0000_CAFE, 1'b0, FLAG_HASH, 7'd10, 1'b0, 6'd0));
        send_request(make_req(MODE_HEXL, 32'd0, 1'b0, FLAG_HASH, 7'd0, 1'b0, 6'd0));
        send_request(make_req(MODE_HEXU, 32'd0, 1'b0, FLAG_HASH, 7'd0, 1'b1, 6'd0));
        send_request(make_req(MODE_CHAR, 32'h0000_0041, 1'b0, FLAG_ZERO, 7'd4, 1'b0, 6'd0));
        send_request(make_req(MODE_CHAR, 32'hFFFF_FF00, 1'b1, FLAG_MINUS, 7'd3, 1'b1, 6'd63));
        send_request(make_req(MODE_RSVD_A, 32'd7, 1'b0, FLAG_NONE, 7'd9, 1'b0, 6'd0));
        send_request(make_req(MODE_RSVD_B, 32'd7, 1'b0, FLAG_MINUS, 7'd9, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'hFFFF_FFFF, 1'b0, FLAG_RSVD_A, 7'd6, 1'b0, 6'd0));
        send_request(make_req(MODE_HEXL, 32'h0000_00FF, 1'b0, FLAG_RSVD_B, 7'd6, 1'b0, 6'd0));
        send_request(make_req(MODE_SDEC, 32'h8000_0000, 1'b0, FLAG_MINUS, 7'd127, 1'b0, 6'd0));
        send_request(make_req(MODE_HEXU, 32'hFFFF_FFFF, 1'b0, FLAG_HASH, 7'd127, 1'b1, 6'd63));
    endtask

    task automatic test_random();
        format_req_t req;
        int unsigned sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            req = rand_request();
            send_request(req);
            if (req.mode <= MODE_CHAR)
                sent++;
        end
    endtask

    task automatic test_backpressure();
        long_hold_req <= 1'b1;
        idle_enable = 1'b0;
        repeat (BURST_ITEMS) send_request(rand_request());
        long_hold_req <= 1'b0;
        idle_enable = 1'b1;
    endtask

    task automatic test_streaming();
        idle_enable = 1'b0;
        repeat (BURST_ITEMS) send_request(rand_request());
        idle_enable = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        long_hold_req = 1'b0;
        idle_enable = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_streaming();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
